/* hw/rtl/amb_pkg.sv */
// Shared types, constants and helpers for the alpha mask bounding box block.
`timescale 1ns / 1ps

package amb_pkg;

    localparam int MAX_DIM   = 4096;
    localparam int CNT_SPAN  = 4096;
    localparam int DIM_LIM   = (MAX_DIM < CNT_SPAN) ? MAX_DIM : CNT_SPAN;

    localparam int DIM_W     = 13;
    localparam int COORD_W   = 12;
    localparam int ALPHA_W   = 8;
    localparam int PIX_W     = 32;
    localparam int ALPHA_LSB = 24;
    localparam int CFG_IDX_W = 2;

    localparam int RES_BITS  = 1 + 8 * COORD_W;
    localparam int RES_W     = ((RES_BITS + 7) / 8) * 8;

    localparam logic [DIM_W-1:0]   WIDTH_RST  = DIM_W'(640);
    localparam logic [DIM_W-1:0]   HEIGHT_RST = DIM_W'(480);
    localparam logic [ALPHA_W-1:0] THR_RST    = ALPHA_W'(32);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_ALPHA_THR    = 2'd2
    } amb_reg_idx_t;

    typedef struct packed {
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic [ALPHA_W-1:0] threshold;
    } amb_cfg_t;

    typedef struct packed {
        logic               found;
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] right;
        logic [COORD_W-1:0] bottom;
        logic [COORD_W-1:0] center_col;
        logic [COORD_W-1:0] center_row;
        logic [COORD_W-1:0] span_w;
        logic [COORD_W-1:0] span_h;
    } amb_result_t;

    // zero reads as one, anything above the counter span saturates
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > DIM_W'(DIM_LIM)) begin
            r = DIM_W'(DIM_LIM);
        end
        return r;
    endfunction

endpackage

/* hw/rtl/alpha_mask_bounding_box.sv */
// A pixel word waits in the input register and updates the box as it leaves;
// on the last pixel of a frame the result word is loaded then and valid until taken.
// Throughput: one pixel word per cycle, one result word per frame; the only
// stall is a frame end meeting a result register that is still held.
// Reset (aresetn low, synchronous): size 640x480, threshold 32, counters and
// box cleared, both registers empty.
`timescale 1ns / 1ps

module alpha_mask_bounding_box (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [amb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [amb_pkg::DIM_W-1:0]           cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [31:0] pixel_word
    input  logic [amb_pkg::PIX_W-1:0]           s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] box_found, [12:1] box_left, [24:13] box_top, [36:25] box_right,
    // [48:37] box_bottom, [60:49] center_col, [72:61] center_row,
    // [84:73] box_span_w, [96:85] box_span_h, [103:97] zero
    output logic [amb_pkg::RES_W-1:0]           m_axis_tdata
);

    amb_pkg::amb_cfg_t     cfg;
    amb_pkg::amb_result_t  res;
    logic                  res_push;
    logic                  res_ready;

    amb_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    amb_track u_track (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .pix_valid (s_axis_tvalid),
        .pix_alpha (s_axis_tdata[amb_pkg::PIX_W-1:amb_pkg::ALPHA_LSB]),
        .pix_ready (s_axis_tready),
        .res_push  (res_push),
        .res_ready (res_ready),
        .res       (res)
    );

    amb_out u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .res_push      (res_push),
        .res           (res),
        .res_ready     (res_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

/* hw/rtl/amb_cfg.sv */
// Configuration registers with effective frame size.
`timescale 1ns / 1ps

module amb_cfg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [amb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [amb_pkg::DIM_W-1:0]          cfg_wdata,
    output amb_pkg::amb_cfg_t                  cfg
);

    logic [amb_pkg::DIM_W-1:0]   width_reg,  width_next;
    logic [amb_pkg::DIM_W-1:0]   height_reg, height_next;
    logic [amb_pkg::ALPHA_W-1:0] thr_reg,    thr_next;

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        thr_next    = thr_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                amb_pkg::REG_FRAME_WIDTH:  width_next  = cfg_wdata;
                amb_pkg::REG_FRAME_HEIGHT: height_next = cfg_wdata;
                amb_pkg::REG_ALPHA_THR:    thr_next    = cfg_wdata[amb_pkg::ALPHA_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= amb_pkg::WIDTH_RST;
            height_reg <= amb_pkg::HEIGHT_RST;
            thr_reg    <= amb_pkg::THR_RST;
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
            thr_reg    <= thr_next;
        end
    end

    assign cfg.width     = amb_pkg::eff_dim(width_reg);
    assign cfg.height    = amb_pkg::eff_dim(height_reg);
    assign cfg.threshold = thr_reg;

endmodule

/* hw/rtl/amb_track.sv */
// Input register, raster counters and running box extents.
`timescale 1ns / 1ps

module amb_track (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  amb_pkg::amb_cfg_t                 cfg,
    input  logic                              pix_valid,
    input  logic [amb_pkg::ALPHA_W-1:0]       pix_alpha,
    output logic                              pix_ready,
    output logic                              res_push,
    input  logic                              res_ready,
    output amb_pkg::amb_result_t              res
);

    localparam int DW = amb_pkg::DIM_W;
    localparam int CW = amb_pkg::COORD_W;

    logic                          in_valid_reg, in_valid_next;
    logic [amb_pkg::ALPHA_W-1:0]   alpha_reg,    alpha_next;
    logic [CW-1:0]                 col_reg,      col_next;
    logic [CW-1:0]                 row_reg,      row_next;
    logic [DW-1:0]                 min_col_reg,  min_col_next;
    logic [DW-1:0]                 min_row_reg,  min_row_next;
    logic [CW-1:0]                 max_col_reg,  max_col_next;
    logic [CW-1:0]                 max_row_reg,  max_row_next;
    logic                          found_reg,    found_next;

    logic          hit, last_col, last_row, frame_end, advance;
    logic [DW-1:0] col_ext, row_ext;
    logic [DW-1:0] min_col_upd, min_row_upd;
    logic [CW-1:0] max_col_upd, max_row_upd;
    logic [DW-1:0] sum_col, sum_row;

    assign col_ext   = {1'b0, col_reg};
    assign row_ext   = {1'b0, row_reg};
    assign hit       = alpha_reg > cfg.threshold;
    assign last_col  = (col_ext + DW'(1)) >= cfg.width;
    assign last_row  = (row_ext + DW'(1)) >= cfg.height;
    assign frame_end = last_col && last_row;
    assign advance   = in_valid_reg && (!frame_end || res_ready);
    assign pix_ready = !in_valid_reg || advance;
    assign res_push  = advance && frame_end;

    always_comb begin
        min_col_upd = (hit && col_ext < min_col_reg) ? col_ext : min_col_reg;
        min_row_upd = (hit && row_ext < min_row_reg) ? row_ext : min_row_reg;
        max_col_upd = (hit && col_reg > max_col_reg) ? col_reg : max_col_reg;
        max_row_upd = (hit && row_reg > max_row_reg) ? row_reg : max_row_reg;
        sum_col     = min_col_upd + {1'b0, max_col_upd};
        sum_row     = min_row_upd + {1'b0, max_row_upd};
    end

    // result of the frame that closes on this word
    always_comb begin
        res = '0;
        if (found_reg || hit) begin
            res.found      = 1'b1;
            res.left       = min_col_upd[CW-1:0];
            res.top        = min_row_upd[CW-1:0];
            res.right      = max_col_upd;
            res.bottom     = max_row_upd;
            res.center_col = sum_col[DW-1:1];
            res.center_row = sum_row[DW-1:1];
            res.span_w     = max_col_upd - min_col_upd[CW-1:0];
            res.span_h     = max_row_upd - min_row_upd[CW-1:0];
        end
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        alpha_next    = alpha_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        min_col_next  = min_col_reg;
        min_row_next  = min_row_reg;
        max_col_next  = max_col_reg;
        max_row_next  = max_row_reg;
        found_next    = found_reg;
        if (pix_ready) begin
            in_valid_next = pix_valid;
            alpha_next    = pix_alpha;
        end
        if (advance) begin
            if (frame_end) begin
                col_next     = '0;
                row_next     = '0;
                min_col_next = cfg.width;
                min_row_next = cfg.height;
                max_col_next = '0;
                max_row_next = '0;
                found_next   = 1'b0;
            end else begin
                min_col_next = min_col_upd;
                min_row_next = min_row_upd;
                max_col_next = max_col_upd;
                max_row_next = max_row_upd;
                found_next   = found_reg || hit;
                if (!last_col) begin
                    col_next = col_reg + CW'(1);
                end else begin
                    col_next = '0;
                    row_next = row_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        alpha_reg <= alpha_next;
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            col_reg      <= '0;
            row_reg      <= '0;
            min_col_reg  <= amb_pkg::eff_dim(amb_pkg::WIDTH_RST);
            min_row_reg  <= amb_pkg::eff_dim(amb_pkg::HEIGHT_RST);
            max_col_reg  <= '0;
            max_row_reg  <= '0;
            found_reg    <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            min_col_reg  <= min_col_next;
            min_row_reg  <= min_row_next;
            max_col_reg  <= max_col_next;
            max_row_reg  <= max_row_next;
            found_reg    <= found_next;
        end
    end

    a_empty_max_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !found_reg |-> (max_col_reg == '0 && max_row_reg == '0))
        else $error("extents moved without a foreground pixel");

    a_box_ordered: assert property (@(posedge aclk) disable iff (!aresetn)
        found_reg |-> (min_col_reg <= {1'b0, max_col_reg} &&
                       min_row_reg <= {1'b0, max_row_reg}))
        else $error("box min above max");

    a_push_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        res_push |=> (!found_reg && col_reg == '0 && row_reg == '0))
        else $error("frame state not cleared after result");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(col_reg) &&
                                        $stable(row_reg)))
        else $error("stalled word lost or counters moved");

endmodule

/* hw/rtl/amb_out.sv */
// Result register and output word packing.
`timescale 1ns / 1ps

module amb_out (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           res_push,
    input  amb_pkg::amb_result_t           res,
    output logic                           res_ready,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [amb_pkg::RES_W-1:0]      m_axis_tdata
);

    logic                  out_valid_reg, out_valid_next;
    amb_pkg::amb_result_t  out_reg,       out_next;

    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_push) begin
            out_valid_next = 1'b1;
            out_next       = res;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(amb_pkg::RES_W - amb_pkg::RES_BITS)'(0),
                            out_reg.span_h, out_reg.span_w,
                            out_reg.center_row, out_reg.center_col,
                            out_reg.bottom, out_reg.right,
                            out_reg.top, out_reg.left, out_reg.found};

endmodule

/* sim/alpha_mask_bounding_box_tb.sv */
// Self-checking testbench for alpha_mask_bounding_box: directed, size-saturation and random frames.
`timescale 1ns / 1ps

module alpha_mask_bounding_box_tb;

    import amb_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int RUN_LIMIT = 100000;
    localparam int SETTLE_CYCLES = 4;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]     cfg_wdata = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [PIX_W-1:0]     s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [RES_W-1:0]     m_axis_tdata;

    // predictor copy of the registers and the frame state
    logic [DIM_W-1:0]   set_width;
    logic [DIM_W-1:0]   set_height;
    logic [ALPHA_W-1:0] set_thr;
    logic [COORD_W-1:0] pix_col;
    logic [COORD_W-1:0] pix_row;
    logic [DIM_W-1:0]   min_c;
    logic [DIM_W-1:0]   min_r;
    logic [COORD_W-1:0] max_c;
    logic [COORD_W-1:0] max_r;
    logic               seen_fg;

    amb_result_t pending_boxes[$];
    int pixels_sent = 0;
    int bad_boxes = 0;
    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    int cycles = 0;

    alpha_mask_bounding_box u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        // [31:0] pixel_word
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // [0] box_found, [12:1] box_left, [24:13] box_top, [36:25] box_right,
        // [48:37] box_bottom, [60:49] center_col, [72:61] center_row,
        // [84:73] box_span_w, [96:85] box_span_h, [103:97] zero
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > RUN_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // 0 counts as 1, oversize saturates to the counter span
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        return (v == '0) ? DIM_W'(1) : ((v > DIM_W'(DIM_LIM)) ? DIM_W'(DIM_LIM) : v);
    endfunction

    function automatic string fmt_box(input amb_result_t b);
        return $sformatf("found=%0d l=%0d t=%0d r=%0d b=%0d cc=%0d cr=%0d w=%0d h=%0d",
                         b.found, b.left, b.top, b.right, b.bottom,
                         b.center_col, b.center_row, b.span_w, b.span_h);
    endfunction

    function automatic amb_result_t unpack_box(input logic [RES_W-1:0] d);
        amb_result_t b;
        b.found      = d[0];
        b.left       = d[12:1];
        b.top        = d[24:13];
        b.right      = d[36:25];
        b.bottom     = d[48:37];
        b.center_col = d[60:49];
        b.center_row = d[72:61];
        b.span_w     = d[84:73];
        b.span_h     = d[96:85];
        return b;
    endfunction

    task automatic report_bad(input string msg);
        bad_boxes++;
        if (bad_boxes <= 10) begin
            $display("[%0t] %s", $realtime, msg);
        end
    endtask

    task automatic clear_box_state();
        pix_col = '0;
        pix_row = '0;
        min_c   = clamp_dim(set_width);
        min_r   = clamp_dim(set_height);
        max_c   = '0;
        max_r   = '0;
        seen_fg = 1'b0;
    endtask

    task automatic box_track_pixel(input logic [PIX_W-1:0] px);
        logic [DIM_W-1:0]   w;
        logic [DIM_W-1:0]   h;
        logic [DIM_W:0]     sum_c;
        logic [DIM_W:0]     sum_r;
        amb_result_t        box;
        w = clamp_dim(set_width);
        h = clamp_dim(set_height);
        if (px[PIX_W-1:ALPHA_LSB] > set_thr) begin
            if ({1'b0, pix_col} < min_c) min_c = {1'b0, pix_col};
            if ({1'b0, pix_row} < min_r) min_r = {1'b0, pix_row};
            if (pix_col > max_c) max_c = pix_col;
            if (pix_row > max_r) max_r = pix_row;
            seen_fg = 1'b1;
        end
        if ({1'b0, pix_col} + DIM_W'(1) < w) begin
            pix_col++;
        end else begin
            pix_col = '0;
            if ({1'b0, pix_row} + DIM_W'(1) < h) begin
                pix_row++;
            end else begin
                box = '0;
                if (seen_fg) begin
                    sum_c          = min_c + max_c;
                    sum_r          = min_r + max_r;
                    box.found      = 1'b1;
                    box.left       = min_c[COORD_W-1:0];
                    box.top        = min_r[COORD_W-1:0];
                    box.right      = max_c;
                    box.bottom     = max_r;
                    box.center_col = sum_c[COORD_W:1];
                    box.center_row = sum_r[COORD_W:1];
                    box.span_w     = max_c - min_c[COORD_W-1:0];
                    box.span_h     = max_r - min_r[COORD_W-1:0];
                end
                pending_boxes.push_back(box);
                clear_box_state();
            end
        end
    endtask

    always @(posedge aclk) begin : check_box
        amb_result_t got;
        amb_result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = unpack_box(m_axis_tdata);
            if (pending_boxes.size() == 0) begin
                report_bad({"unexpected box: ", fmt_box(got)});
            end else begin
                want = pending_boxes.pop_front();
                if (got !== want) begin
                    report_bad({"box mismatch exp ", fmt_box(want), " act ", fmt_box(got)});
                end
            end
        end
    end

    task automatic send_pixel(input logic [PIX_W-1:0] px);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        box_track_pixel(px);
        pixels_sent++;
    endtask

    task automatic await_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_boxes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // leaves cfg_wr_en high; caller lowers it after the last write
    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            REG_FRAME_WIDTH:  set_width  = val;
            REG_FRAME_HEIGHT: set_height = val;
            REG_ALPHA_THR:    set_thr    = val[ALPHA_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_frame(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                             input logic [ALPHA_W-1:0] thr, input bit spare);
        await_idle();
        put_reg(REG_FRAME_WIDTH, w);
        put_reg(REG_FRAME_HEIGHT, h);
        put_reg(REG_ALPHA_THR, DIM_W'(thr));
        if (spare) put_reg(REG_SPARE, DIM_W'($urandom));
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [PIX_W-1:0] make_pixel(input int fg_pct);
        logic [ALPHA_W-1:0] a;
        if ($urandom_range(99) < fg_pct && set_thr != 8'hFF) begin
            if ($urandom_range(3) == 0) a = set_thr + 8'd1;
            else a = ALPHA_W'($urandom_range(255, int'(set_thr) + 1));
        end else begin
            if ($urandom_range(3) == 0) a = set_thr;
            else a = ALPHA_W'($urandom_range(int'(set_thr), 0));
        end
        return {a, 24'($urandom)};
    endfunction

    task automatic send_frame(input int fg_pct);
        do begin
            send_pixel(make_pixel(fg_pct));
        end while (pix_col != '0 || pix_row != '0);
    endtask

    task automatic test_directed();
        // single pixel frames around the threshold
        set_frame(13'd1, 13'd1, 8'd32, 1'b0);
        send_pixel({8'd33, 24'h000000});
        send_pixel({8'd32, 24'hFFFFFF});
        send_pixel({8'hFF, 24'h123456});
        send_pixel({8'h00, 24'hABCDEF});
        // 3x2 with threshold 0
        set_frame(13'd3, 13'd2, 8'd0, 1'b0);
        send_pixel({8'h00, 24'h0});
        send_pixel({8'h01, 24'h0});
        send_pixel({8'h00, 24'hFFFFFF});
        send_pixel({8'h00, 24'h0});
        send_pixel({8'h00, 24'h0});
        send_pixel({8'h01, 24'h0});
        // nothing passes the top threshold; spare index must be ignored
        set_frame(13'd2, 13'd1, 8'hFF, 1'b1);
        send_pixel({8'hFF, 24'hFFFFFF});
        send_pixel({8'hFF, 24'hFFFFFF});
        // zero sizes act as one
        set_frame(13'd0, 13'd0, 8'd254, 1'b0);
        send_pixel({8'hFF, 24'h0});
        // size shrinks in the middle of a frame
        set_frame(13'd4, 13'd4, 8'd16, 1'b0);
        send_pixel({8'h00, 24'h0});
        send_pixel({8'h00, 24'h0});
        send_pixel({8'h00, 24'h0});
        send_pixel({8'h00, 24'h0});
        send_pixel({8'h00, 24'h0});
        send_pixel({8'h80, 24'h0});
        await_idle();
        put_reg(REG_FRAME_WIDTH, 13'd2);
        put_reg(REG_FRAME_HEIGHT, 13'd1);
        cfg_wr_en <= 1'b0;
        send_frame(100);
    endtask

    // oversize sizes saturate; each saturated frame is closed early by shrinking the size
    task automatic test_full_span();
        set_frame(13'h1FFF, 13'h1FFF, 8'd0, 1'b0);
        send_pixel({8'hFF, 24'h0});
        repeat (5) send_pixel({8'h00, 24'h0});
        send_pixel({8'h10, 24'h0});
        await_idle();
        put_reg(REG_FRAME_WIDTH, 13'd2);
        put_reg(REG_FRAME_HEIGHT, 13'd1);
        cfg_wr_en <= 1'b0;
        send_frame(50);
        set_frame(13'd0, 13'h1FFF, 8'd0, 1'b0);
        send_pixel({8'h00, 24'h0});
        send_pixel({8'h40, 24'h0});
        repeat (3) send_pixel({8'h00, 24'h0});
        await_idle();
        put_reg(REG_FRAME_HEIGHT, 13'd3);
        cfg_wr_en <= 1'b0;
        send_frame(50);
    endtask

    function automatic logic [DIM_W-1:0] pick_dim(input int hi);
        int r;
        r = $urandom_range(99);
        if (r < 10) return '0;
        if (r < 15) return DIM_W'($urandom_range(16, 9));
        return DIM_W'($urandom_range(hi, 1));
    endfunction

    task automatic test_random_frames(input int src_pct, input int snk_pct, input int budget);
        int start;
        int setting_start;
        int r;
        logic [ALPHA_W-1:0] thr;
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        start = pixels_sent;
        while (pixels_sent - start < budget) begin
            r = $urandom_range(9);
            thr = (r == 0) ? 8'd0 : ((r == 1) ? 8'hFF : ALPHA_W'($urandom));
            set_frame(pick_dim(8), pick_dim(5), thr, $urandom_range(4) == 0);
            setting_start = pixels_sent;
            while (pixels_sent - setting_start < 40 && pixels_sent - start < budget) begin
                case ($urandom_range(3))
                    0: send_frame(0);
                    1: send_frame(5);
                    2: send_frame(25);
                    default: send_frame(60);
                endcase
            end
        end
    endtask

    initial begin
        set_width  = WIDTH_RST;
        set_height = HEIGHT_RST;
        set_thr    = THR_RST;
        clear_box_state();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_full_span();
        test_random_frames(0, 0, 130);
        test_random_frames(85, 0, 130);
        test_random_frames(0, 85, 130);
        test_random_frames(23, 23, 130);

        await_idle();
        repeat (10) @(posedge aclk);
        if (pending_boxes.size() != 0) begin
            report_bad("boxes still expected at end of run");
        end
        if (bad_boxes == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* alpha_mask_bounding_box.f */
hw/rtl/amb_pkg.sv
hw/rtl/amb_cfg.sv
hw/rtl/amb_track.sv
hw/rtl/amb_out.sv
hw/rtl/alpha_mask_bounding_box.sv
sim/alpha_mask_bounding_box_tb.sv
